// ----- rtl/krdh_pkg.sv -----
package krdh_pkg;

  // field widths of the stream words
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned DIR_IDX_W  = 6;
  localparam int unsigned DIRS_W     = 4 * DIR_IDX_W;
  localparam int unsigned DEADLINE_W = 34;

  localparam int unsigned S_DATA_W   = KEY_W + TIME_W;
  localparam int unsigned M_DATA_W   = 3 * KEY_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_DELAY   = 3'd0,
    REG_REPEAT_PERIOD  = 3'd1,
    REG_DIAGONAL_DELAY = 3'd2,
    REG_LOCK_MASK      = 3'd3,
    REG_PLAYER0_DIRS   = 3'd4,
    REG_PLAYER1_DIRS   = 3'd5
  } cfg_reg_t;

  // reset values of the registers
  localparam logic [MS_W-1:0] REPEAT_DELAY_RST   = 16'd500;
  localparam logic [MS_W-1:0] REPEAT_PERIOD_RST  = 16'd100;
  localparam logic [MS_W-1:0] DIAGONAL_DELAY_RST = 16'd20;

  // parameter defaults
  localparam int unsigned NUM_KEYS_DEF    = 64;
  localparam int unsigned NUM_PLAYERS_DEF = 2;

  typedef enum logic [1:0] {
    DIAG_UNPRESSED = 2'd0,
    DIAG_PRESSED   = 2'd1,
    DIAG_SUSTAIN   = 2'd2
  } diag_st_t;

endpackage

// ----- rtl/key_repeat_diagonal_hold.sv -----
// typematic key repeat with sticky diagonal hold
//
// input stream: one word per poll, the physical key vector and a wrapping
// millisecond time. output stream: one word per poll, the held keys after
// diagonal hold, the pressed keys (newly held, or all held keys outside the
// lock mask on an auto-repeat) and the released keys; tuser flags a repeat.
// configuration: cfg_we writes cfg_data to register cfg_index (0 repeat
// delay, 1 repeat period, 2 diagonal delay, 3 lock mask, 4/5 player dirs);
// write only while no poll is in flight.
//
// a word taken into the input register moves on to the output register when
// the output can advance, which raises m_tvalid. one poll is taken every
// cycle while m_tready keeps the output moving; the longest path is the two
// diagonal machines in series over the held keys.
// the output register and input register stall together when m_tready is
// low, so the input keeps taking a word while a result waits, until both
// stages are full.
// rst (synchronous) clears the key state, restores the register defaults
// and empties both stages.
module key_repeat_diagonal_hold #(
  parameter int unsigned NUM_KEYS    = krdh_pkg::NUM_KEYS_DEF,
  parameter int unsigned NUM_PLAYERS = krdh_pkg::NUM_PLAYERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [krdh_pkg::S_DATA_W-1:0]       s_tdata,   // key_state, now_ms
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [krdh_pkg::M_DATA_W-1:0]       m_tdata,   // down, pressed, released
  output logic                                m_tuser,   // repeat_fired
  input  logic                                cfg_we,
  input  logic [krdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [krdh_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import krdh_pkg::*;

  // registers
  logic [MS_W-1:0]      repeat_delay;
  logic [MS_W-1:0]      repeat_period;
  logic [MS_W-1:0]      diagonal_delay;
  logic [NUM_KEYS-1:0]  lock_mask;
  logic [DIRS_W-1:0]    dirs [NUM_PLAYERS];

  // key state
  logic [NUM_KEYS-1:0]  held_keys;
  logic [NUM_KEYS-1:0]  last_physical;
  logic [TIME_W-1:0]    last_time;
  logic [TIME_W-1:0]    repeat_accum;
  logic                 first_repeat;
  diag_st_t             diag_status   [NUM_PLAYERS];
  logic [1:0]           diag_corner   [NUM_PLAYERS];
  logic [DEADLINE_W-1:0] diag_deadline [NUM_PLAYERS];

  // input stage
  logic                 in_valid;
  logic [NUM_KEYS-1:0]  in_keys;
  logic [TIME_W-1:0]    in_now;

  // output stage
  logic                 out_valid;
  logic [NUM_KEYS-1:0]  out_down;
  logic [NUM_KEYS-1:0]  out_pressed;
  logic [NUM_KEYS-1:0]  out_released;
  logic                 out_fired;

  // next values
  logic [NUM_KEYS-1:0]  held_mid;
  logic [NUM_KEYS-1:0]  held_keys_next;
  logic [TIME_W-1:0]    repeat_accum_next;
  logic                 first_repeat_next;
  logic                 fired;
  logic [NUM_KEYS-1:0]  pressed;
  diag_st_t             diag_status_next   [NUM_PLAYERS];
  logic [1:0]           diag_corner_next   [NUM_PLAYERS];
  logic [DEADLINE_W-1:0] diag_deadline_next [NUM_PLAYERS];

  logic advance;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // read a key bit by 6-bit index; indices past the key count read as up
  function automatic logic key_bit(input logic [NUM_KEYS-1:0] v,
                                   input logic [DIR_IDX_W-1:0] idx);
    logic r;
    r = 1'b0;
    for (int j = 0; j < NUM_KEYS; j++) begin
      if (idx == DIR_IDX_W'(j)) r = v[j];
    end
    return r;
  endfunction

  // held keys follow physical keys on changed bits only
  assign held_mid = (held_keys & ~(in_keys ^ last_physical)) |
                    (in_keys & (in_keys ^ last_physical));

  // repeat timing
  always_comb begin
    logic [TIME_W-1:0] acc;
    logic              first;
    if (held_mid == held_keys) begin
      acc   = repeat_accum + (in_now - last_time);
      first = first_repeat;
    end else begin
      acc   = '0;
      first = 1'b1;
    end
    fired = 1'b0;
    if (first && acc > TIME_W'(repeat_delay)) begin
      acc   = acc - TIME_W'(repeat_delay);
      fired = 1'b1;
    end else if (!first && acc > TIME_W'(repeat_period)) begin
      acc   = acc - TIME_W'(repeat_period);
      fired = 1'b1;
    end
    repeat_accum_next = acc;
    first_repeat_next = fired ? 1'b0 : first;
    pressed = fired ? (held_mid & ~lock_mask) : (held_mid & ~held_keys);
  end

  // sticky diagonal machines, player 0 first, each sees the previous writes
  always_comb begin
    logic [NUM_KEYS-1:0]   hv;
    logic [DIR_IDX_W-1:0]  idx [4];
    logic                  cur [4];
    logic                  phy [4];
    logic [1:0]            cd;
    logic [1:0]            c1;
    logic [1:0]            c2;
    logic [1:0]            c3;
    diag_st_t              st;
    logic [1:0]            cr;
    logic [DEADLINE_W-1:0] dl;
    logic [DEADLINE_W-1:0] now_x;
    now_x = DEADLINE_W'(in_now);
    hv    = held_mid;
    for (int p = 0; p < NUM_PLAYERS; p++) begin
      cd = diag_corner[p];
      c1 = cd + 2'd1;
      c2 = cd + 2'd2;
      c3 = cd + 2'd3;
      st = diag_status[p];
      cr = diag_corner[p];
      dl = diag_deadline[p];
      for (int k = 0; k < 4; k++) begin
        idx[k] = dirs[p][DIR_IDX_W*k +: DIR_IDX_W];
        cur[k] = key_bit(hv, idx[k]);
        phy[k] = key_bit(in_keys, idx[k]);
      end
      // opposing key ends a sustain
      if (st == DIAG_SUSTAIN && (cur[c2] || cur[c3])) begin
        st      = DIAG_UNPRESSED;
        dl      = '0;
        cur[cd] = phy[cd];
        cur[c1] = phy[c1];
      end
      if (st == DIAG_PRESSED && (cur[cd] || cur[c1])) begin
        st = DIAG_SUSTAIN;
        dl = now_x + DEADLINE_W'(diagonal_delay);
      end
      // first adjacent pair held picks the corner
      for (int k = 0; k < 4; k++) begin
        if (st == DIAG_UNPRESSED && cur[k] && cur[(k + 1) % 4]) begin
          cr = 2'(k);
          st = DIAG_PRESSED;
          dl = '0;
        end
      end
      if (st == DIAG_SUSTAIN && dl > now_x) begin
        cur[cd] = 1'b1;
        cur[c1] = 1'b1;
      end
      if (st == DIAG_SUSTAIN && (dl <= now_x || (!phy[cd] && !phy[c1]))) begin
        st      = DIAG_UNPRESSED;
        cur[cd] = phy[cd];
        cur[c1] = phy[c1];
      end
      // write back up, right, down, left; last write to a shared key wins
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < NUM_KEYS; j++) begin
          if (idx[k] == DIR_IDX_W'(j)) hv[j] = cur[k];
        end
      end
      diag_status_next[p]   = st;
      diag_corner_next[p]   = cr;
      diag_deadline_next[p] = dl;
    end
    held_keys_next = hv;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay   <= REPEAT_DELAY_RST;
      repeat_period  <= REPEAT_PERIOD_RST;
      diagonal_delay <= DIAGONAL_DELAY_RST;
      lock_mask      <= '0;
      for (int p = 0; p < NUM_PLAYERS; p++) dirs[p] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPEAT_DELAY:   repeat_delay   <= cfg_data[MS_W-1:0];
        REG_REPEAT_PERIOD:  repeat_period  <= cfg_data[MS_W-1:0];
        REG_DIAGONAL_DELAY: diagonal_delay <= cfg_data[MS_W-1:0];
        REG_LOCK_MASK:      lock_mask      <= cfg_data[NUM_KEYS-1:0];
        REG_PLAYER0_DIRS:   dirs[0]        <= cfg_data[DIRS_W-1:0];
        REG_PLAYER1_DIRS: begin
          if (NUM_PLAYERS > 1) dirs[NUM_PLAYERS-1] <= cfg_data[DIRS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_keys <= s_tdata[NUM_KEYS-1:0];
      in_now  <= s_tdata[KEY_W +: TIME_W];
    end
  end

  // state update and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      held_keys     <= '0;
      last_physical <= '0;
      last_time     <= '0;
      repeat_accum  <= '0;
      first_repeat  <= 1'b1;
      for (int p = 0; p < NUM_PLAYERS; p++) begin
        diag_status[p]   <= DIAG_UNPRESSED;
        diag_corner[p]   <= '0;
        diag_deadline[p] <= '0;
      end
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        held_keys     <= held_keys_next;
        last_physical <= in_keys;
        last_time     <= in_now;
        repeat_accum  <= repeat_accum_next;
        first_repeat  <= first_repeat_next;
        for (int p = 0; p < NUM_PLAYERS; p++) begin
          diag_status[p]   <= diag_status_next[p];
          diag_corner[p]   <= diag_corner_next[p];
          diag_deadline[p] <= diag_deadline_next[p];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_down     <= held_keys_next;
      out_pressed  <= pressed;
      out_released <= held_keys & ~held_keys_next;
      out_fired    <= fired;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {KEY_W'(out_released), KEY_W'(out_pressed), KEY_W'(out_down)};
  assign m_tuser  = out_fired;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import krdh_pkg::*;

  // generous bound; the slowest legal run is far below this
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [KEY_W-1:0] down;
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] released;
    logic             fired;
  } poll_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;   // key_state, now_ms
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;          // down, pressed, released
  logic                  m_tuser;          // repeat_fired
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // idling controls of the sender and the receiver
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  int rx_hold_len = 0;

  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  poll_result_t expected_polls[$];
  poll_result_t want;

  // mirror of the configuration registers
  logic [MS_W-1:0]   rep_delay_ms  = REPEAT_DELAY_RST;
  logic [MS_W-1:0]   rep_period_ms = REPEAT_PERIOD_RST;
  logic [MS_W-1:0]   diag_hold_ms  = DIAGONAL_DELAY_RST;
  logic [KEY_W-1:0]  lock_keys     = '0;
  logic [DIRS_W-1:0] player_dirs [2] = '{default: '0};

  // mirror of the key and diagonal state
  logic [KEY_W-1:0]      held_keys     = '0;
  logic [KEY_W-1:0]      prior_keys    = '0;
  logic [KEY_W-1:0]      phys_keys     = '0;
  logic [TIME_W-1:0]     last_ms       = '0;
  logic [TIME_W-1:0]     repeat_accum  = '0;
  logic                  first_repeat  = 1'b1;
  diag_st_t              diag_state    [2] = '{default: DIAG_UNPRESSED};
  logic [1:0]            diag_corner   [2] = '{default: '0};
  logic [DEADLINE_W-1:0] diag_deadline [2] = '{default: '0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  key_repeat_diagonal_hold u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sticky diagonal machine of one player over its four direction keys
  function automatic void diag_hold(input int p, input logic [KEY_W-1:0] phys,
                                    input logic [TIME_W-1:0] now);
    logic [DIR_IDX_W-1:0]  idx [4];
    logic                  cur [4];
    logic                  pin [4];
    logic [1:0]            cd, c1, c2, c3, nk;
    logic [DEADLINE_W-1:0] now_x;
    int                    k;
    cd    = diag_corner[p];
    c1    = cd + 2'd1;
    c2    = cd + 2'd2;
    c3    = cd + 2'd3;
    now_x = {2'b00, now};
    for (k = 0; k < 4; k++) begin
      idx[k] = player_dirs[p][DIR_IDX_W*k +: DIR_IDX_W];
      cur[k] = held_keys[idx[k]];
      pin[k] = phys[idx[k]];
    end
    // an opposing key ends a sustain at once
    if (diag_state[p] == DIAG_SUSTAIN && (cur[c2] || cur[c3])) begin
      diag_state[p]    = DIAG_UNPRESSED;
      diag_deadline[p] = '0;
      cur[cd]          = pin[cd];
      cur[c1]          = pin[c1];
    end
    if (diag_state[p] == DIAG_PRESSED && (cur[cd] || cur[c1])) begin
      diag_state[p]    = DIAG_SUSTAIN;
      diag_deadline[p] = now_x + DEADLINE_W'(diag_hold_ms);
    end
    // first corner found wins
    for (k = 0; k < 4; k++) begin
      nk = 2'(k) + 2'd1;
      if (diag_state[p] == DIAG_UNPRESSED && cur[k] && cur[nk]) begin
        diag_corner[p]   = 2'(k);
        diag_state[p]    = DIAG_PRESSED;
        diag_deadline[p] = '0;
      end
    end
    if (diag_state[p] == DIAG_SUSTAIN && diag_deadline[p] > now_x) begin
      cur[cd] = 1'b1;
      cur[c1] = 1'b1;
    end
    if (diag_state[p] == DIAG_SUSTAIN &&
        (diag_deadline[p] <= now_x || (!pin[cd] && !pin[c1]))) begin
      diag_state[p] = DIAG_UNPRESSED;
      cur[cd]       = pin[cd];
      cur[c1]       = pin[c1];
    end
    // written back up, right, down, left: last write to a shared key wins
    for (k = 0; k < 4; k++) held_keys[idx[k]] = cur[k];
  endfunction

  // one poll: held and repeat bookkeeping, then both players' diagonals
  function automatic poll_result_t typematic_step(input logic [KEY_W-1:0] phys,
                                                  input logic [TIME_W-1:0] now);
    logic [KEY_W-1:0] changed;
    poll_result_t     r;
    prior_keys = held_keys;
    changed    = phys ^ phys_keys;
    held_keys  = (held_keys & ~changed) | (phys & changed);
    phys_keys  = phys;
    if (held_keys == prior_keys) begin
      repeat_accum = repeat_accum + (now - last_ms);
    end else begin
      repeat_accum = '0;
      first_repeat = 1'b1;
    end
    r.fired = 1'b0;
    if (first_repeat && repeat_accum > TIME_W'(rep_delay_ms)) begin
      repeat_accum = repeat_accum - TIME_W'(rep_delay_ms);
      r.fired      = 1'b1;
    end else if (!first_repeat && repeat_accum > TIME_W'(rep_period_ms)) begin
      repeat_accum = repeat_accum - TIME_W'(rep_period_ms);
      r.fired      = 1'b1;
    end
    if (r.fired) begin
      r.pressed    = held_keys & ~lock_keys;
      first_repeat = 1'b0;
    end else begin
      r.pressed = held_keys & ~prior_keys;
    end
    last_ms = now;
    diag_hold(0, phys, now);
    diag_hold(1, phys, now);
    r.down     = held_keys;
    r.released = prior_keys & ~held_keys;
    return r;
  endfunction

  // offer one poll word, wait for it to be taken, then queue its result
  task automatic send_poll(input logic [KEY_W-1:0] keys, input logic [TIME_W-1:0] now);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    cfg_we <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, keys};
    do @(posedge clk); while (!s_tready);
    expected_polls.push_back(typematic_step(keys, now));
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_polls.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write; the mirror keeps only the register's own width
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_REPEAT_DELAY:   rep_delay_ms   = value[MS_W-1:0];
      REG_REPEAT_PERIOD:  rep_period_ms  = value[MS_W-1:0];
      REG_DIAGONAL_DELAY: diag_hold_ms   = value[MS_W-1:0];
      REG_LOCK_MASK:      lock_keys      = value[KEY_W-1:0];
      REG_PLAYER0_DIRS:   player_dirs[0] = value[DIRS_W-1:0];
      REG_PLAYER1_DIRS:   player_dirs[1] = value[DIRS_W-1:0];
      default: ;
    endcase
  endtask

  // register defaults: first and later repeat, all keys, time wrap
  task automatic test_reset_defaults();
    send_poll('0, 32'd0);
    send_poll(64'h20, 32'd10);
    send_poll(64'h20, 32'd511);          // first repeat just past 500 ms
    send_poll(64'h20, 32'd600);
    send_poll(64'h20, 32'd615);          // later repeat past 100 ms
    send_poll('1, 32'd700);
    send_poll('0, 32'd701);              // everything released
    send_poll(64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF);
    send_poll(64'hAAAA_AAAA_AAAA_AAAA, 32'd5);   // elapsed time across the wrap
  endtask

  // zero and full-scale repeat timing, lock mask extremes
  task automatic test_repeat_extremes();
    settle();
    write_reg(REG_REPEAT_DELAY, 64'hDEAD_BEEF_1234_0000);
    write_reg(REG_REPEAT_PERIOD, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(REG_LOCK_MASK, 64'hF0F0_0F0F_F0F0_0F0F);
    send_poll(64'hFF00_0000_0000_00FF, 32'd1000);
    send_poll(64'hFF00_0000_0000_00FF, 32'd1000);  // no elapsed time, no repeat
    send_poll(64'hFF00_0000_0000_00FF, 32'd1001);
    send_poll(64'hFF00_0000_0000_00FF, 32'd1002);
    settle();
    write_reg(REG_REPEAT_DELAY, 64'hFFFF);
    write_reg(REG_REPEAT_PERIOD, 64'hFFFF);
    write_reg(REG_LOCK_MASK, '1);                  // repeats report nothing
    send_poll(64'h8000_0000_0000_0001, 32'd5000);
    send_poll(64'h8000_0000_0000_0001, 32'd70536);
    send_poll(64'h8000_0000_0000_0001, 32'd136071);
  endtask

  // corner hold, deadline, physical release, opposing key, deadline past
  // a time wrap, and a second player whose up and right share one key
  task automatic test_diagonal_hold();
    settle();
    write_reg(REG_REPEAT_DELAY, 64'hFFFF);
    write_reg(REG_LOCK_MASK, '0);
    write_reg(REG_DIAGONAL_DELAY, 64'd20);
    write_reg(REG_PLAYER0_DIRS, {40'd0, 6'd3, 6'd2, 6'd1, 6'd0});
    write_reg(REG_PLAYER1_DIRS, {40'd0, 6'd11, 6'd63, 6'd10, 6'd10});
    send_poll(64'h3, 32'd1001);                 // up and right: corner taken
    send_poll(64'h2, 32'd1005);                 // up let go, still shown held
    send_poll(64'h2, 32'd1030);                 // deadline passed
    send_poll(64'h3, 32'd1040);
    send_poll(64'h6, 32'd1041);
    send_poll(64'h4, 32'd1042);                 // down opposes the corner
    send_poll(64'hC03, 32'hFFFF_FFF0);
    send_poll(64'h802, 32'hFFFF_FFFA);          // deadline lands past the wrap
    send_poll(64'h2, 32'd5);
    send_poll(64'h0, 32'd6);                    // both corner keys released
  endtask

  // receiver holds off long enough that the block fills and stalls input
  task automatic test_backpressure();
    int n;
    settle();
    tx_idle     = 1'b0;
    rx_hold_len = 80;
    for (n = 0; n < 30; n++) send_poll(KEY_W'($urandom_range(0, 255)), 32'(2000 + 3 * n));
    tx_idle = 1'b1;
  endtask

  function automatic logic [MS_W-1:0] pick_ms(input int phase);
    if (phase == 0) return '0;
    if (phase == 1) return '1;
    return MS_W'($urandom_range(0, 200));
  endfunction

  function automatic logic [DIR_IDX_W-1:0] pick_dir();
    if ($urandom_range(0, 9) == 0) return DIR_IDX_W'($urandom_range(0, 63));
    return DIR_IDX_W'($urandom_range(0, 7));
  endfunction

  // phases of random polls; keys mostly move one at a time within a small
  // pool that the direction keys share, so holds, repeats and corners happen
  task automatic test_random_polls();
    logic [KEY_W-1:0]  keys;
    logic [TIME_W-1:0] now;
    logic [KEY_W-1:0]  lock;
    int                phase, n;
    keys = '0;
    now  = $urandom;
    for (phase = 0; phase < 6; phase++) begin
      settle();
      lock = (phase == 0) ? '0 : (phase == 1) ? '1 : {$urandom, $urandom};
      write_reg(REG_REPEAT_DELAY, {$urandom, 16'($urandom), pick_ms(phase)});
      write_reg(REG_REPEAT_PERIOD, {$urandom, 16'($urandom), pick_ms(phase)});
      write_reg(REG_DIAGONAL_DELAY, {$urandom, 16'($urandom), pick_ms(phase)});
      write_reg(REG_LOCK_MASK, lock);
      write_reg(REG_PLAYER0_DIRS, {$urandom, 8'($urandom),
                                   pick_dir(), pick_dir(), pick_dir(), pick_dir()});
      write_reg(REG_PLAYER1_DIRS, {$urandom, 8'($urandom),
                                   pick_dir(), pick_dir(), pick_dir(), pick_dir()});
      for (n = 0; n < 330; n++) begin
        // idling turns on and off in stretches
        if (n % 110 == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        case ($urandom_range(0, 19))
          0:            keys = {$urandom, $urandom};
          1:            keys = '0;
          2, 3, 4, 5,
          6, 7, 8, 9:   keys[$urandom_range(0, 7)] ^= 1'b1;
          default: ;
        endcase
        case ($urandom_range(0, 19))
          0:       now = $urandom;
          1:       ;
          2:       now = now + TIME_W'($urandom_range(0, 131072));
          default: now = now + TIME_W'($urandom_range(1, 40));
        endcase
        send_poll(keys, now);
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver: a random stall before each word, or a long hold when asked
  initial begin : receiver
    int stall;
    wait (!rst);
    forever begin
      stall = rx_idle ? $urandom_range(0, 4) : 0;
      if (rx_hold_len > 0) begin
        stall       = rx_hold_len;
        rx_hold_len = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic check_field(input string name, input logic [KEY_W-1:0] exp_val,
                             input logic [KEY_W-1:0] got_val);
    if (exp_val !== got_val) begin
      mismatch_count++;
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, got_val);
    end
  endtask

  // each result word against the oldest outstanding poll
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_polls.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with no poll outstanding, expected none, got %h",
                 $time, m_tdata);
      end else begin
        want = expected_polls.pop_front();
        check_field("down_keys", want.down, m_tdata[KEY_W-1:0]);
        check_field("pressed_keys", want.pressed, m_tdata[2*KEY_W-1:KEY_W]);
        check_field("released_keys", want.released, m_tdata[3*KEY_W-1:2*KEY_W]);
        check_field("repeat_fired", KEY_W'(want.fired), KEY_W'(m_tuser));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_repeat_extremes();
    test_diagonal_hold();
    test_backpressure();
    test_random_polls();
    settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
